FILE: rtl/sli_pkg.sv
// Shared types and status codes for the segment and axis-line intersection block.
`timescale 1ns / 1ps
`default_nettype none

package sli_pkg;

  // Result status codes carried on the result channel's tuser.
  typedef logic [1:0] sli_status_t;

  localparam sli_status_t ST_NONE     = 2'd0;
  localparam sli_status_t ST_CROSS    = 2'd1;
  localparam sli_status_t ST_PARALLEL = 2'd2;

  // Per-item flags that ride along the pipeline.
  typedef struct packed {
    logic par_hit;   // parallel segment on the line with an end inside the span
    logic cross_ok;  // crossing parameter lies in [0,1)
    logic neg;       // the along-line delta q1 - q0 is negative
  } sli_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/sli_front.sv
// Front stage: axis selection, differences, sign normalisation and parallel test.
`timescale 1ns / 1ps
`default_nettype none

module sli_front #(
  parameter int CW = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      up_ready,
  input  wire logic                 op,
  input  wire logic signed [CW-1:0] sx,
  input  wire logic signed [CW-1:0] sy,
  input  wire logic signed [CW-1:0] ex,
  input  wire logic signed [CW-1:0] ey,
  input  wire logic signed [CW-1:0] pos,
  input  wire logic signed [CW-1:0] lo,
  input  wire logic signed [CW-1:0] hi,
  input  wire logic                 dn_ready,
  output logic                      valid_r,
  output sli_pkg::sli_ctl_t         ctl_r,
  output logic [CW-1:0]             num_r,
  output logic [CW-1:0]             den_r,
  output logic [CW-1:0]             mag_r,
  output logic signed [CW-1:0]      q0_r,
  output logic signed [CW-1:0]      lo_r,
  output logic signed [CW-1:0]      hi_r
);
  import sli_pkg::*;

  logic signed [CW-1:0] p0, p1, q0, q1;
  logic signed [CW:0]   dp, dn, dq;
  logic signed [CW:0]   dp_abs, dq_abs, num_s;
  sli_ctl_t             ctl_nxt;

  // Pick the across-line and along-line coordinates for the line's orientation.
  always_comb begin
    p0 = op ? sy : sx;
    p1 = op ? ey : ex;
    q0 = op ? sx : sy;
    q1 = op ? ex : ey;
  end

  // Differences one bit wider than the coordinates, then normalise the
  // crossing fraction so that its denominator is positive.
  always_comb begin
    dp     = {p1[CW-1], p1} - {p0[CW-1], p0};
    dn     = {pos[CW-1], pos} - {p0[CW-1], p0};
    dq     = {q1[CW-1], q1} - {q0[CW-1], q0};
    dp_abs = dp[CW] ? -dp : dp;
    num_s  = dp[CW] ? -dn : dn;
    dq_abs = dq[CW] ? -dq : dq;
  end

  // Classify the item.
  always_comb begin
    ctl_nxt.par_hit  = (dp == '0) && (p0 == pos) &&
                       (((lo <= q0) && (q0 < hi)) || ((lo < q1) && (q1 < hi)));
    ctl_nxt.cross_ok = (dp != '0) && !num_s[CW] && (num_s[CW-1:0] < dp_abs[CW-1:0]);
    ctl_nxt.neg      = dq[CW];
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && in_valid) begin
      ctl_r <= ctl_nxt;
      num_r <= num_s[CW-1:0];
      den_r <= dp_abs[CW-1:0];
      mag_r <= dq_abs[CW-1:0];
      q0_r  <= q0;
      lo_r  <= lo;
      hi_r  <= hi;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sli_mul.sv
// Multiply stage: forms the scaled numerator num * |q1 - q0|.
`timescale 1ns / 1ps
`default_nettype none

module sli_mul #(
  parameter int CW = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      up_ready,
  input  wire sli_pkg::sli_ctl_t    ctl,
  input  wire logic [CW-1:0]        num,
  input  wire logic [CW-1:0]        den,
  input  wire logic [CW-1:0]        mag,
  input  wire logic signed [CW-1:0] q0,
  input  wire logic signed [CW-1:0] lo,
  input  wire logic signed [CW-1:0] hi,
  input  wire logic                 dn_ready,
  output logic                      valid_r,
  output sli_pkg::sli_ctl_t         ctl_r,
  output logic [2*CW-1:0]           prod_r,
  output logic [CW-1:0]             den_r,
  output logic signed [CW-1:0]      q0_r,
  output logic signed [CW-1:0]      lo_r,
  output logic signed [CW-1:0]      hi_r
);
  import sli_pkg::*;

  logic [2*CW-1:0] prod_nxt;

  // Full-width unsigned product.
  assign prod_nxt = {{CW{1'b0}}, num} * {{CW{1'b0}}, mag};

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && in_valid) begin
      ctl_r  <= ctl;
      prod_r <= prod_nxt;
      den_r  <= den;
      q0_r   <= q0;
      lo_r   <= lo;
      hi_r   <= hi;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sli_div_cell.sv
// One restoring-division cell: produces one quotient bit and passes the item on.
`timescale 1ns / 1ps
`default_nettype none

module sli_div_cell #(
  parameter int CW = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      up_ready,
  input  wire sli_pkg::sli_ctl_t    ctl,
  input  wire logic [CW-1:0]        rem,
  input  wire logic [CW-1:0]        low,
  input  wire logic [CW-1:0]        quo,
  input  wire logic [CW-1:0]        den,
  input  wire logic signed [CW-1:0] q0,
  input  wire logic signed [CW-1:0] lo,
  input  wire logic signed [CW-1:0] hi,
  input  wire logic                 dn_ready,
  output logic                      valid_r,
  output sli_pkg::sli_ctl_t         ctl_r,
  output logic [CW-1:0]             rem_r,
  output logic [CW-1:0]             low_r,
  output logic [CW-1:0]             quo_r,
  output logic [CW-1:0]             den_r,
  output logic signed [CW-1:0]      q0_r,
  output logic signed [CW-1:0]      lo_r,
  output logic signed [CW-1:0]      hi_r
);
  import sli_pkg::*;

  logic [CW:0]   rem_sh, rem_sub;
  logic          qbit;
  logic [CW-1:0] rem_nxt;

  // Shift in the next dividend bit and subtract the divisor where it fits.
  always_comb begin
    rem_sh  = {rem, low[CW-1]};
    rem_sub = rem_sh - {1'b0, den};
    qbit    = (rem_sh >= {1'b0, den});
    rem_nxt = qbit ? rem_sub[CW-1:0] : rem_sh[CW-1:0];
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && in_valid) begin
      ctl_r <= ctl;
      rem_r <= rem_nxt;
      low_r <= {low[CW-2:0], 1'b0};
      quo_r <= {quo[CW-2:0], qbit};
      den_r <= den;
      q0_r  <= q0;
      lo_r  <= lo;
      hi_r  <= hi;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sli_back.sv
// Back stage: rounding, offset from the start point, span test and output register.
`timescale 1ns / 1ps
`default_nettype none

module sli_back #(
  parameter int CW = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      up_ready,
  input  wire sli_pkg::sli_ctl_t    ctl,
  input  wire logic [CW-1:0]        rem,
  input  wire logic [CW-1:0]        quo,
  input  wire logic [CW-1:0]        den,
  input  wire logic signed [CW-1:0] q0,
  input  wire logic signed [CW-1:0] lo,
  input  wire logic signed [CW-1:0] hi,
  input  wire logic                 dn_ready,
  output logic                      valid_r,
  output sli_pkg::sli_status_t      status_r,
  output logic [CW-1:0]             coord_r
);
  import sli_pkg::*;

  logic                 round_up;
  logic [CW:0]          off;
  logic signed [CW+1:0] q_ext, off_ext, q_s, lo_ext, hi_ext;
  logic                 cross_hit;
  sli_status_t          status_nxt;
  logic [CW-1:0]        coord_nxt;

  // Round half away from zero: bump the quotient when 2*rem >= den.
  always_comb begin
    round_up = ({rem, 1'b0} >= {1'b0, den});
    off      = {1'b0, quo} + {{CW{1'b0}}, round_up};
  end

  // Apply the offset in the direction of the segment and test the open span.
  always_comb begin
    q_ext     = {{2{q0[CW-1]}}, q0};
    off_ext   = {1'b0, off};
    q_s       = ctl.neg ? (q_ext - off_ext) : (q_ext + off_ext);
    lo_ext    = {{2{lo[CW-1]}}, lo};
    hi_ext    = {{2{hi[CW-1]}}, hi};
    cross_hit = ctl.cross_ok && (q_s > lo_ext) && (q_s < hi_ext);
  end

  always_comb begin
    if (ctl.par_hit) begin
      status_nxt = ST_PARALLEL;
      coord_nxt  = '0;
    end else if (cross_hit) begin
      status_nxt = ST_CROSS;
      coord_nxt  = q_s[CW-1:0];
    end else begin
      status_nxt = ST_NONE;
      coord_nxt  = '0;
    end
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && in_valid) begin
      status_r <= status_nxt;
      coord_r  <= coord_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/segment_axis_line_intersect.sv
// Top level: intersection of a segment with an axis-aligned line and a span on it.
//
// Input channel (in_*): one transaction per test, carrying the segment end
// points, the line position and the span bounds in in_tdata, and the line
// orientation in in_tuser (0 vertical, 1 horizontal).
// Result channel (out_*): one transaction per input, with the hit status in
// out_tuser (0 none, 1 crossing, 2 parallel overlap) and the crossing
// coordinate in out_tdata (zero unless the status is a crossing).
// The pipeline holds a front stage, a multiply stage, one division cell per
// quotient bit (COORD_BITS cells), and the output stage. Throughput is one
// transaction per cycle while out_tready is high; every stage holds its own item.
// A stage advances whenever it is empty or its successor advances, so the
// block keeps accepting while the result register waits, until all stages
// are full. When the receiver stalls with the pipeline full, in_tready drops.
// Reset clears all stage valid flags; no items are held afterwards.
`timescale 1ns / 1ps
`default_nettype none

module segment_axis_line_intersect #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_tvalid,
  output logic                                        in_tready,
  // in_tdata, lowest bits first: start_x, start_y, end_x, end_y,
  // line_pos, span_low, span_high, then zero padding
  input  wire logic [((7*COORD_BITS+7)/8)*8-1:0]     in_tdata,
  // in_tuser: op
  input  wire logic                                   in_tuser,
  output logic                                        out_tvalid,
  input  wire logic                                   out_tready,
  // out_tdata, lowest bits first: cross_coord, then zero padding
  output logic [((COORD_BITS+7)/8)*8-1:0]            out_tdata,
  // out_tuser: hit_status
  output sli_pkg::sli_status_t                        out_tuser
);
  import sli_pkg::*;

  localparam int CW    = COORD_BITS;
  localparam int OUT_W = ((COORD_BITS+7)/8)*8;

  // Field unpacking.
  logic signed [CW-1:0] sx, sy, ex, ey, pos, lo, hi;

  assign sx  = in_tdata[0*CW +: CW];
  assign sy  = in_tdata[1*CW +: CW];
  assign ex  = in_tdata[2*CW +: CW];
  assign ey  = in_tdata[3*CW +: CW];
  assign pos = in_tdata[4*CW +: CW];
  assign lo  = in_tdata[5*CW +: CW];
  assign hi  = in_tdata[6*CW +: CW];

  // Front stage outputs.
  logic                 f_valid;
  sli_ctl_t             f_ctl;
  logic [CW-1:0]        f_num, f_den, f_mag;
  logic signed [CW-1:0] f_q0, f_lo, f_hi;

  // Multiply stage outputs.
  logic                 m_up_ready, m_valid;
  sli_ctl_t             m_ctl;
  logic [2*CW-1:0]      m_prod;
  logic [CW-1:0]        m_den;
  logic signed [CW-1:0] m_q0, m_lo, m_hi;

  // Division chain: index 0 feeds the first cell, index CW leaves the last.
  logic                 c_valid [0:CW];
  sli_ctl_t             c_ctl   [0:CW];
  logic [CW-1:0]        c_rem   [0:CW];
  logic [CW-1:0]        c_low   [0:CW];
  logic [CW-1:0]        c_quo   [0:CW];
  logic [CW-1:0]        c_den   [0:CW];
  logic signed [CW-1:0] c_q0    [0:CW];
  logic signed [CW-1:0] c_lo    [0:CW];
  logic signed [CW-1:0] c_hi    [0:CW];
  logic                 c_ready [0:CW];

  // Back stage.
  logic                 b_up_ready;
  logic [CW-1:0]        b_coord;

  sli_front #(.CW(CW)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .up_ready (in_tready),
    .op       (in_tuser),
    .sx       (sx),
    .sy       (sy),
    .ex       (ex),
    .ey       (ey),
    .pos      (pos),
    .lo       (lo),
    .hi       (hi),
    .dn_ready (m_up_ready),
    .valid_r  (f_valid),
    .ctl_r    (f_ctl),
    .num_r    (f_num),
    .den_r    (f_den),
    .mag_r    (f_mag),
    .q0_r     (f_q0),
    .lo_r     (f_lo),
    .hi_r     (f_hi)
  );

  sli_mul #(.CW(CW)) u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (f_valid),
    .up_ready (m_up_ready),
    .ctl      (f_ctl),
    .num      (f_num),
    .den      (f_den),
    .mag      (f_mag),
    .q0       (f_q0),
    .lo       (f_lo),
    .hi       (f_hi),
    .dn_ready (c_ready[0]),
    .valid_r  (m_valid),
    .ctl_r    (m_ctl),
    .prod_r   (m_prod),
    .den_r    (m_den),
    .q0_r     (m_q0),
    .lo_r     (m_lo),
    .hi_r     (m_hi)
  );

  // The product's upper half is the starting partial remainder; its lower
  // half is shifted in one bit per cell.
  assign c_valid[0] = m_valid;
  assign c_ctl[0]   = m_ctl;
  assign c_rem[0]   = m_prod[2*CW-1:CW];
  assign c_low[0]   = m_prod[CW-1:0];
  assign c_quo[0]   = '0;
  assign c_den[0]   = m_den;
  assign c_q0[0]    = m_q0;
  assign c_lo[0]    = m_lo;
  assign c_hi[0]    = m_hi;
  assign c_ready[CW] = b_up_ready;

  for (genvar i = 0; i < CW; i++) begin : g_cell
    sli_div_cell #(.CW(CW)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (c_valid[i]),
      .up_ready (c_ready[i]),
      .ctl      (c_ctl[i]),
      .rem      (c_rem[i]),
      .low      (c_low[i]),
      .quo      (c_quo[i]),
      .den      (c_den[i]),
      .q0       (c_q0[i]),
      .lo       (c_lo[i]),
      .hi       (c_hi[i]),
      .dn_ready (c_ready[i+1]),
      .valid_r  (c_valid[i+1]),
      .ctl_r    (c_ctl[i+1]),
      .rem_r    (c_rem[i+1]),
      .low_r    (c_low[i+1]),
      .quo_r    (c_quo[i+1]),
      .den_r    (c_den[i+1]),
      .q0_r     (c_q0[i+1]),
      .lo_r     (c_lo[i+1]),
      .hi_r     (c_hi[i+1])
    );
  end

  sli_back #(.CW(CW)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (c_valid[CW]),
    .up_ready (b_up_ready),
    .ctl      (c_ctl[CW]),
    .rem      (c_rem[CW]),
    .quo      (c_quo[CW]),
    .den      (c_den[CW]),
    .q0       (c_q0[CW]),
    .lo       (c_lo[CW]),
    .hi       (c_hi[CW]),
    .dn_ready (out_tready),
    .valid_r  (out_tvalid),
    .status_r (out_tuser),
    .coord_r  (b_coord)
  );

  // Zero-extend the coordinate to whole bytes.
  assign out_tdata = OUT_W'(b_coord);

endmodule

`default_nettype wire

FILE: verif/segment_axis_line_intersect_tb.sv
// Testbench for the segment and axis-line intersection block, checked against a built-in predictor.
`timescale 1ns / 1ps

module segment_axis_line_intersect_tb;
  import sli_pkg::*;

  localparam int W          = 16;
  localparam int IN_W       = ((7 * W + 7) / 8) * 8;
  localparam int OUT_W      = ((W + 7) / 8) * 8;
  localparam int N_RANDOM   = 600;
  localparam int DRAIN      = 3 * (W + 3);
  localparam int CYCLE_CAP  = 200000;
  localparam int PRINT_CAP  = 40;

  // One test: a segment, an axis line and a span along that line.
  typedef struct {
    logic    op;
    shortint sx;
    shortint sy;
    shortint ex;
    shortint ey;
    shortint pos;
    shortint lo;
    shortint hi;
  } axis_test_t;

  typedef struct {
    sli_status_t  status;
    logic [W-1:0] coord;
  } hit_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  // in_tdata, lowest bits first: start_x, start_y, end_x, end_y,
  // line_pos, span_low, span_high
  logic [IN_W-1:0]   in_tdata = '0;
  // in_tuser: op
  logic              in_tuser = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  // out_tdata, lowest bits first: cross_coord
  logic [OUT_W-1:0]  out_tdata;
  // out_tuser: hit_status
  sli_status_t       out_tuser;

  axis_test_t  edge_test_q[$];
  hit_result_t hit_expect_q[$];

  logic in_taken = 1'b0;
  logic out_taken = 1'b0;
  bit   in_quiet = 1'b0;
  bit   out_quiet = 1'b0;
  int   in_gap = 0;
  int   out_stall = 0;
  int   err_cnt = 0;
  int   cycles = 0;
  int   result_idx = 0;

  segment_axis_line_intersect #(.COORD_BITS(W)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Prints one mismatch line and counts it; printing stops after a cap.
  task automatic report_error(input string msg);
    if (err_cnt < PRINT_CAP) $display("ERROR @%0d: %s", cycles, msg);
    err_cnt++;
  endtask

  // Expected status and crossing coordinate, using exact integer arithmetic.
  function automatic hit_result_t predict_clip_hit(axis_test_t t);
    longint p0, p1, q0, q1, num, den, dq, mag, off, q;
    hit_result_t r;
    r.status = ST_NONE;
    r.coord  = '0;
    p0 = t.op ? t.sy : t.sx;
    p1 = t.op ? t.ey : t.ex;
    q0 = t.op ? t.sx : t.sy;
    q1 = t.op ? t.ex : t.ey;
    if (p0 == p1) begin
      // Parallel: the start may sit on the lower bound, the end may not.
      if (p0 == t.pos && ((t.lo <= q0 && t.hi > q0) || (t.lo < q1 && t.hi > q1)))
        r.status = ST_PARALLEL;
    end else begin
      num = t.pos - p0;
      den = p1 - p0;
      if (den < 0) begin
        num = -num;
        den = -den;
      end
      // The crossing parameter must lie in [0,1).
      if (num >= 0 && num < den) begin
        dq  = q1 - q0;
        mag = (dq < 0) ? -dq : dq;
        // Round half away from zero on the magnitude.
        off = (2 * num * mag + den) / (2 * den);
        q   = (dq < 0) ? q0 - off : q0 + off;
        if (t.lo < q && q < t.hi) begin
          r.status = ST_CROSS;
          r.coord  = q[W-1:0];
        end
      end
    end
    return r;
  endfunction

  // Uniform value in [a, b], clamped to the coordinate range.
  function automatic shortint pick(input int a, input int b);
    int lo_v, hi_v;
    lo_v = (a < b) ? a : b;
    hi_v = (a < b) ? b : a;
    if (lo_v < -32768) lo_v = -32768;
    if (hi_v > 32767) hi_v = 32767;
    if (lo_v > 32767) lo_v = 32767;
    if (hi_v < -32768) hi_v = -32768;
    return shortint'(lo_v + int'($urandom_range(hi_v - lo_v)));
  endfunction

  function automatic shortint rnd_coord(input int scale);
    return pick(-scale - 1, scale);
  endfunction

  task automatic add_test(input logic op, input shortint sx, input shortint sy,
                          input shortint ex, input shortint ey, input shortint pos,
                          input shortint lo, input shortint hi);
    axis_test_t t;
    t.op  = op;
    t.sx  = sx;
    t.sy  = sy;
    t.ex  = ex;
    t.ey  = ey;
    t.pos = pos;
    t.lo  = lo;
    t.hi  = hi;
    edge_test_q.push_back(t);
  endtask

  // Source: directed cases, then random tests; then wait for the drain.
  initial begin
    axis_test_t t;
    int scale, kind, qmin, qmax;

    // Plain crossings on both orientations, and a reversed segment.
    add_test(1'b0, 0, 0, 10, 10, 5, -100, 100);
    add_test(1'b1, 0, 0, 10, 10, 5, -100, 100);
    add_test(1'b0, 10, 10, 0, 0, 5, -100, 100);
    // Start on the line counts, end on the line does not.
    add_test(1'b0, 3, 7, 9, 1, 3, 0, 100);
    add_test(1'b0, 3, 7, 9, 1, 9, -100, 100);
    // Exact halves round away from zero in both directions.
    add_test(1'b0, 0, 0, 2, 1, 1, -10, 10);
    add_test(1'b0, 0, 0, 2, -1, 1, -10, 10);
    // Crossing exactly on either span bound is excluded.
    add_test(1'b0, 0, 0, 10, 10, 5, 5, 100);
    add_test(1'b0, 0, 0, 10, 10, 5, -100, 5);
    // Line beyond the segment.
    add_test(1'b0, 0, 0, 10, 10, 20, -100, 100);
    // Parallel: start on the lower bound, only the end inside, end on the lower bound,
    // start on the upper bound, horizontal, off the line, and a single point.
    add_test(1'b0, 4, 2, 4, 9, 4, 2, 5);
    add_test(1'b0, 4, -5, 4, 3, 4, 2, 5);
    add_test(1'b0, 4, 9, 4, 2, 4, 2, 5);
    add_test(1'b0, 4, 5, 4, 9, 4, 2, 5);
    add_test(1'b1, 1, 6, 9, 6, 6, 0, 4);
    add_test(1'b0, 4, 2, 4, 3, 5, -100, 100);
    add_test(1'b0, 4, 3, 4, 3, 4, 0, 10);
    // Empty and inverted spans.
    add_test(1'b0, 0, 0, 10, 10, 5, 5, 5);
    add_test(1'b0, 0, 0, 10, 10, 5, 100, -100);
    // Coordinate extremes.
    add_test(1'b0, -32768, -32768, 32767, 32767, 0, -32768, 32767);
    add_test(1'b1, -32768, 32767, 32767, -32768, -1, -32768, 32767);
    add_test(1'b0, -32768, 32767, 32767, -32768, 32766, -32768, 32767);
    add_test(1'b0, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    add_test(1'b1, -32768, -32768, -32768, -32768, -32768, -32768, 32767);

    // Random tests: mostly crossings and parallel cases at mixed scales, some noise.
    for (int n = 0; n < N_RANDOM; n++) begin
      case ($urandom_range(0, 3))
        0: scale = 4;
        1: scale = 40;
        2: scale = 2000;
        default: scale = 32767;
      endcase
      kind = $urandom_range(0, 9);
      t.op = $urandom_range(0, 1);
      if (kind == 0) begin
        t.sx  = shortint'($urandom());
        t.sy  = shortint'($urandom());
        t.ex  = shortint'($urandom());
        t.ey  = shortint'($urandom());
        t.pos = shortint'($urandom());
        t.lo  = shortint'($urandom());
        t.hi  = shortint'($urandom());
      end else begin
        t.sx = rnd_coord(scale);
        t.sy = rnd_coord(scale);
        t.ex = rnd_coord(scale);
        t.ey = rnd_coord(scale);
        // Parallel cases: copy the across-line coordinate.
        if (kind <= 3) begin
          if (t.op) t.ey = t.sy;
          else t.ex = t.sx;
        end
        if (t.op) t.pos = pick(t.sy, t.ey);
        else t.pos = pick(t.sx, t.ex);
        if (kind <= 3 && $urandom_range(0, 4) == 0) t.pos = rnd_coord(scale);
        qmin = t.op ? ((t.sx < t.ex) ? t.sx : t.ex) : ((t.sy < t.ey) ? t.sy : t.ey);
        qmax = t.op ? ((t.sx < t.ex) ? t.ex : t.sx) : ((t.sy < t.ey) ? t.ey : t.sy);
        case ($urandom_range(0, 4))
          0: begin
            t.lo = -32768;
            t.hi = 32767;
          end
          1: begin
            t.lo = rnd_coord(scale);
            t.hi = rnd_coord(scale);
          end
          default: begin
            t.lo = pick(qmin - 2, qmax + 2);
            t.hi = pick(t.lo, qmax + 3);
          end
        endcase
      end
      edge_test_q.push_back(t);
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (edge_test_q.size() != 0 || in_tvalid || hit_expect_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Input driver: holds a transaction until taken, then waits a random gap.
  always @(negedge clk) begin
    axis_test_t nxt;
    if (rst_n) begin
      if (in_taken || !in_tvalid) begin
        if (in_taken) begin
          if ($urandom_range(0, 39) == 0) in_quiet = !in_quiet;
          in_gap = in_quiet ? 0 : $urandom_range(0, 6);
        end
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (edge_test_q.size() != 0) begin
          nxt = edge_test_q.pop_front();
          in_tdata  <= {nxt.hi, nxt.lo, nxt.pos, nxt.ey, nxt.ex, nxt.sy, nxt.sx};
          in_tuser  <= nxt.op;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: after each taken result, stalls for a random number of cycles.
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_taken) begin
        if ($urandom_range(0, 39) == 0) out_quiet = !out_quiet;
        out_stall = out_quiet ? 0 : $urandom_range(0, 6);
      end
      if (out_stall > 0) begin
        out_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Monitor: predicts on each accepted input, checks each accepted result.
  always @(posedge clk) begin
    axis_test_t  seen;
    hit_result_t want;
    if (!rst_n) begin
      in_taken  <= 1'b0;
      out_taken <= 1'b0;
    end else begin
      cycles++;
      if (cycles == CYCLE_CAP) begin
        $display("TIMEOUT after %0d cycles", cycles);
        $display("DONE: errors detected");
        $finish;
      end
      in_taken  <= in_tvalid && in_tready;
      out_taken <= out_tvalid && out_tready;

      if (out_tvalid && out_tready) begin
        if (hit_expect_q.size() == 0) begin
          report_error($sformatf("result %0d with nothing expected: status %0d coord %0d",
                                 result_idx, out_tuser, $signed(out_tdata[W-1:0])));
        end else begin
          want = hit_expect_q.pop_front();
          if (out_tuser !== want.status)
            report_error($sformatf("result %0d status %0d, expected %0d",
                                   result_idx, out_tuser, want.status));
          if (out_tdata[W-1:0] !== want.coord)
            report_error($sformatf("result %0d coord %0d, expected %0d", result_idx,
                                   $signed(out_tdata[W-1:0]), $signed(want.coord)));
        end
        result_idx++;
      end

      if (in_tvalid && in_tready) begin
        seen.op  = in_tuser;
        seen.sx  = in_tdata[0*W +: W];
        seen.sy  = in_tdata[1*W +: W];
        seen.ex  = in_tdata[2*W +: W];
        seen.ey  = in_tdata[3*W +: W];
        seen.pos = in_tdata[4*W +: W];
        seen.lo  = in_tdata[5*W +: W];
        seen.hi  = in_tdata[6*W +: W];
        hit_expect_q.push_back(predict_clip_hit(seen));
      end
    end
  end

endmodule

FILE: filelist.f
rtl/sli_pkg.sv
rtl/sli_front.sv
rtl/sli_mul.sv
rtl/sli_div_cell.sv
rtl/sli_back.sv
rtl/segment_axis_line_intersect.sv
verif/segment_axis_line_intersect_tb.sv
